/* design/iows_pkg.sv */
// Shared types and constants for the I2C OLED write sequencer.
// No dependencies; every other design file refers to this package by scoped names.
package iows_pkg;

	// Bus symbol codes as they appear on the result channel
	localparam logic [1:0] SYM_START = 2'd0;
	localparam logic [1:0] SYM_BIT   = 2'd1;
	localparam logic [1:0] SYM_ACK   = 2'd2;
	localparam logic [1:0] SYM_STOP  = 2'd3;

	// Control byte that follows the address
	localparam logic [7:0] CTRL_DATA = 8'h40;
	localparam logic [7:0] CTRL_CMD  = 8'h00;

	// Slave address after reset (0x3C shifted left, write bit zero)
	localparam logic [7:0] ADDR_RESET = 8'h78;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE);
	localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(BITS_PER_BYTE - 1);

	// Byte positions in the frame: address, control, value
	localparam logic [1:0] BYTE_ADDR  = 2'd0;
	localparam logic [1:0] BYTE_CTRL  = 2'd1;
	localparam logic [1:0] BYTE_VALUE = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;    // capture value and is_data
		logic emit_start;  // present start, load address byte
		logic emit_bit;    // present MSB of shifter, shift
		logic emit_ack;    // present acknowledge slot, load next byte
		logic emit_stop;   // present stop, end of frame
	} iows_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic adv;         // output register can take a new beat
		logic bit_last;    // current bit is the last of the byte
		logic byte_last;   // current byte is the value byte
	} iows_stat_t;

endpackage

/* design/i2c_oled_write_sequencer.sv */
// Top level of the I2C OLED write sequencer: controller plus datapath.
// Depends on iows_pkg, iows_ctrl and iows_dp.
//
// Usage:
//   Request channel (in_valid/in_ready, value, is_data): one beat is one byte
//   to write, as display data (is_data=1, control byte 0x40) or as a command
//   (is_data=0, control byte 0x00).
//   Symbol channel (out_valid/out_ready, symbol, sda_level, last): each request
//   expands into 29 beats: start, 8 address bits, ack, 8 control bits, ack,
//   8 value bits, ack, stop. last marks the stop beat. On an ack beat
//   sda_level repeats the last data bit; the ack itself is never sampled.
//   Config channel (cfg_valid/cfg_ready, slave_address): always ready; write
//   only while no request is in flight.
// Start: a taken request moves the controller to ST_START, which loads the
//   start beat into the output register once the output side is free.
// Throughput: one symbol per cycle unless out_ready stalls; the next request
//   is taken in the same cycle as the stop beat, so frames run back to back.
//   The rate is set by the single output register, one beat a cycle unless stalled.
// Reset: clears the controller to idle, drops out_valid, and loads the slave
//   address 0x78.
// Stall: while out_ready is low the output beat holds and the sequencer waits;
//   no request is taken until the current frame's stop beat has been issued.
module i2c_oled_write_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] slave_address,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] value,
	input  logic       is_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] symbol,
	output logic       sda_level,
	output logic       last
);

	iows_pkg::iows_cmd_t  cmd;
	iows_pkg::iows_stat_t stat;

	// Address register takes every write at once
	assign cfg_ready = 1'b1;

	iows_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	iows_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (slave_address),
		.value     (value),
		.is_data   (is_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.sda_level (sda_level),
		.last      (last)
	);

endmodule

/* design/iows_ctrl.sv */
// Sequencing state machine for the I2C OLED write sequencer.
// Depends on iows_pkg for the command and status structs.
module iows_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  iows_pkg::iows_stat_t stat,
	output iows_pkg::iows_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_BIT   = 3'd2;
	localparam logic [2:0] ST_ACK   = 3'd3;
	localparam logic [2:0] ST_STOP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	// Take a new request when idle, or in the cycle the stop beat is issued
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_STOP) && stat.adv);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd            = '0;
		cmd.load_req   = accept;
		state_nxt      = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_START;
				end
			end
			ST_START: begin
				if (stat.adv) begin
					cmd.emit_start = 1'b1;
					state_nxt      = ST_BIT;
				end
			end
			ST_BIT: begin
				if (stat.adv) begin
					cmd.emit_bit = 1'b1;
					if (stat.bit_last) begin
						state_nxt = ST_ACK;
					end
				end
			end
			ST_ACK: begin
				if (stat.adv) begin
					cmd.emit_ack = 1'b1;
					state_nxt    = stat.byte_last ? ST_STOP : ST_BIT;
				end
			end
			ST_STOP: begin
				if (stat.adv) begin
					cmd.emit_stop = 1'b1;
					state_nxt     = accept ? ST_START : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* design/iows_dp.sv */
// Datapath for the I2C OLED write sequencer: request hold, shifter, counters, output register.
// Depends on iows_pkg for constants and the command and status structs.
module iows_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [7:0]           cfg_data,
	input  logic [7:0]           value,
	input  logic                 is_data,
	input  iows_pkg::iows_cmd_t  cmd,
	output iows_pkg::iows_stat_t stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           symbol,
	output logic                 sda_level,
	output logic                 last
);

	logic [7:0]                    addr_q;
	logic [7:0]                    held_value_q;
	logic                          held_kind_q;
	logic [7:0]                    shifter_q;
	logic [iows_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [1:0]                    byte_idx_q;
	logic                          sda_hold_q;
	logic                          out_valid_q;
	logic [1:0]                    symbol_q;
	logic                          sda_q;
	logic                          last_q;
	logic [7:0]                    next_byte;
	logic                          emit_any;

	assign emit_any = cmd.emit_start | cmd.emit_bit | cmd.emit_ack | cmd.emit_stop;
	assign next_byte = (byte_idx_q == iows_pkg::BYTE_ADDR)
		? (held_kind_q ? iows_pkg::CTRL_DATA : iows_pkg::CTRL_CMD)
		: held_value_q;

	assign stat.adv       = !out_valid_q || out_ready;
	assign stat.bit_last  = (bit_cnt_q == iows_pkg::BIT_CNT_LAST);
	assign stat.byte_last = (byte_idx_q == iows_pkg::BYTE_VALUE);

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign sda_level = sda_q;
	assign last      = last_q;

	// Configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= iows_pkg::ADDR_RESET;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			byte_idx_q  <= iows_pkg::BYTE_ADDR;
			sda_hold_q  <= 1'b1;
		end else begin
			if (cfg_valid) begin
				addr_q <= cfg_data;
			end
			if (emit_any) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit_start) begin
				bit_cnt_q  <= '0;
				byte_idx_q <= iows_pkg::BYTE_ADDR;
				sda_hold_q <= 1'b0;
			end
			if (cmd.emit_bit) begin
				bit_cnt_q  <= bit_cnt_q + 1'b1;
				sda_hold_q <= shifter_q[7];
			end
			if (cmd.emit_ack) begin
				bit_cnt_q  <= '0;
				byte_idx_q <= stat.byte_last ? iows_pkg::BYTE_ADDR : byte_idx_q + 2'd1;
			end
			if (cmd.emit_stop) begin
				sda_hold_q <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			held_value_q <= value;
			held_kind_q  <= is_data;
		end
		if (cmd.emit_start) begin
			shifter_q <= addr_q;
			symbol_q  <= iows_pkg::SYM_START;
			sda_q     <= 1'b0;
			last_q    <= 1'b0;
		end
		if (cmd.emit_bit) begin
			shifter_q <= {shifter_q[6:0], 1'b0};
			symbol_q  <= iows_pkg::SYM_BIT;
			sda_q     <= shifter_q[7];
			last_q    <= 1'b0;
		end
		if (cmd.emit_ack) begin
			shifter_q <= next_byte;
			symbol_q  <= iows_pkg::SYM_ACK;
			sda_q     <= sda_hold_q;
			last_q    <= 1'b0;
		end
		if (cmd.emit_stop) begin
			symbol_q <= iows_pkg::SYM_STOP;
			sda_q    <= 1'b1;
			last_q   <= 1'b1;
		end
	end

endmodule

/* design/iows_checker.sv */
// Port-level checks for the I2C OLED write sequencer, bound to its top level.
// Depends on iows_pkg for symbol codes.
module iows_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] symbol,
	input logic       sda_level,
	input logic       last
);

	// Hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol)
			&& $stable(sda_level) && $stable(last))
		else $error("stalled symbol beat changed");

	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> symbol == iows_pkg::SYM_STOP)
		else $error("last flag on a non-stop symbol");

	a_stop_releases: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && symbol == iows_pkg::SYM_STOP |-> last && sda_level)
		else $error("stop beat without last or with SDA low");

	a_start_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && symbol == iows_pkg::SYM_START |-> !sda_level && !last)
		else $error("start beat with SDA high or last set");

endmodule

bind i2c_oled_write_sequencer iows_checker u_iows_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.symbol    (symbol),
	.sda_level (sda_level),
	.last      (last)
);

/* bench/iows_symbol_checker.sv */
// Symbol checker for the I2C OLED write sequencer: watches the request, address
// and symbol channels, expands each request into its bus symbols and compares.
// Depends on iows_pkg for symbol codes, control bytes and the reset address.
module iows_symbol_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] slave_address,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] value,
	input  logic       is_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] symbol,
	input  logic       sda_level,
	input  logic       last,
	output int         mismatches,
	output int         symbols_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] symbol;
		logic       sda;
		logic       last;
	} bus_beat_t;

	localparam int REPORT_CAP = 100;

	bus_beat_t  owed_beats [$];
	bus_beat_t  oldest;
	logic [7:0] device_address;
	int         reports;

	// Expand one write into start, three bytes of 8 bits plus an ack, and stop.
	function automatic void expand_write(input logic [7:0] addr, input logic [7:0] v,
			input logic d);
		logic [7:0] shifter;
		logic       level;
		owed_beats.push_back(bus_beat_t'{iows_pkg::SYM_START, 1'b0, 1'b0});
		for (int b = 0; b < 3; b++) begin
			case (b)
				0: shifter = addr;
				1: shifter = d ? iows_pkg::CTRL_DATA : iows_pkg::CTRL_CMD;
				default: shifter = v;
			endcase
			level = 1'b0;
			for (int k = 0; k < 8; k++) begin
				level = shifter[7];
				shifter = shifter << 1;
				owed_beats.push_back(bus_beat_t'{iows_pkg::SYM_BIT, level, 1'b0});
			end
			// ack slot keeps the last bit on SDA
			owed_beats.push_back(bus_beat_t'{iows_pkg::SYM_ACK, level, 1'b0});
		end
		owed_beats.push_back(bus_beat_t'{iows_pkg::SYM_STOP, 1'b1, 1'b1});
	endfunction

	function automatic void compare_field(input string field, input logic [1:0] want,
			input logic [1:0] got);
		if (want !== got) begin
			mismatches++;
			if (reports < REPORT_CAP) begin
				reports++;
				$error("%s: expected %0d, got %0d", field, want, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address = iows_pkg::ADDR_RESET;
			owed_beats.delete();
			mismatches = 0;
			reports = 0;
			symbols_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_beats.size() == 0) begin
					mismatches++;
					if (reports < REPORT_CAP) begin
						reports++;
						$error("symbol: beat %0d with nothing outstanding", symbol);
					end
				end else begin
					oldest = owed_beats.pop_front();
					compare_field("symbol", oldest.symbol, symbol);
					compare_field("sda_level", {1'b0, oldest.sda}, {1'b0, sda_level});
					compare_field("last", {1'b0, oldest.last}, {1'b0, last});
				end
			end
			if (cfg_valid && cfg_ready)
				device_address = slave_address;
			if (in_valid && in_ready)
				expand_write(device_address, value, is_data);
			symbols_owed <= owed_beats.size();
		end
	end

endmodule

/* bench/i2c_oled_write_sequencer_test.sv */
// Testbench top for the I2C OLED write sequencer: drives write requests and
// slave address updates, stalls the symbol channel, and reports the verdict.
// Depends on iows_pkg, the i2c_oled_write_sequencer RTL and iows_symbol_checker.
module i2c_oled_write_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Idle cycles with no beat on any channel before the run is declared hung.
	// A frame is 29 beats, and both the sender gap and the receiver's choked runs
	// are bounded, so this leaves a wide margin.
	localparam int QUIET_LIMIT = 3000;
	// Cycles to hold after the last owed symbol before touching the address
	// or ending the run; a request reaches the start beat through ST_START and the output register.
	localparam int SETTLE = 6;
	localparam int RANDOM_PER_PHASE = 16;
	localparam int PHASES = 5;

	typedef enum int {RX_OPEN, RX_BUSY, RX_TOGGLE, RX_CHOKED} rx_pattern_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] slave_address;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] value;
	logic       is_data;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] symbol;
	logic       sda_level;
	logic       last;

	int          mismatches;
	int          symbols_owed;
	int          burst_left;
	int          quiet;
	int          rx_left;
	rx_pattern_t rx_mode;

	i2c_oled_write_sequencer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.slave_address(slave_address),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.is_data      (is_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol       (symbol),
		.sda_level    (sda_level),
		.last         (last)
	);

	iows_symbol_checker frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.slave_address(slave_address),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.is_data      (is_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol       (symbol),
		.sda_level    (sda_level),
		.last         (last),
		.mismatches   (mismatches),
		.symbols_owed (symbols_owed)
	);

	// 12 ns clock, low half first so the first rising edge is at 6 ns
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver: switch between stall patterns, each held for a random run of
	// cycles, so stalls land on every slot of a frame and some runs never stall.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
			rx_left = $urandom_range(4, 60);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				out_ready <= 1'b1;
			end
			RX_BUSY: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			RX_TOGGLE: begin
				out_ready <= ~out_ready;
			end
			default: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Watchdog: any beat on any channel resets the quiet count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one write request. Requests go out in bursts; between bursts drop
	// valid for a random gap, if any. Within a burst valid stays high and only the
	// payload advances, so valid is never lowered and raised in one step.
	task automatic send_write(input logic [7:0] v, input logic d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		value    <= v;
		is_data  <= d;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	// Write the slave address; only called while the sequencer is idle.
	task automatic write_address(input logic [7:0] a);
		cfg_valid     <= 1'b1;
		slave_address <= a;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Drop the request channel and wait until every owed symbol has come out.
	// The first clock lets the checker's count catch the final request.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (symbols_owed != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		// {is_data, value}: all-zero and all-one bytes of both kinds, a lone MSB
		// and a lone LSB (ack repeats the low bit), alternating patterns, and a lone zero at each end
		logic [8:0] directed [10];
		logic [7:0] phase_addr [PHASES];

		directed = '{
			{1'b0, 8'h00}, {1'b1, 8'h00}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
			{1'b1, 8'h80}, {1'b0, 8'h01}, {1'b1, 8'hAA}, {1'b0, 8'h55},
			{1'b0, 8'h7F}, {1'b1, 8'hFE}
		};
		// address extremes, then random, the reset value again, and random
		phase_addr = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), iows_pkg::ADDR_RESET,
			8'($urandom_range(0, 255))};

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		slave_address = 8'h00;
		in_valid      = 1'b0;
		value         = 8'h00;
		is_data       = 1'b0;
		out_ready     = 1'b0;
		burst_left    = 0;
		quiet         = 0;
		rx_left       = 0;
		rx_mode       = RX_OPEN;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed writes under the reset address
		foreach (directed[i])
			send_write(directed[i][7:0], directed[i][8]);
		drain();

		// Random writes, one address setting per phase
		for (int p = 0; p < PHASES; p++) begin
			write_address(phase_addr[p]);
			send_write(8'hFF, 1'b1);
			send_write(8'h00, 1'b0);
			repeat (RANDOM_PER_PHASE)
				send_write(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			drain();
		end

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
design/iows_pkg.sv
design/iows_ctrl.sv
design/iows_dp.sv
design/i2c_oled_write_sequencer.sv
design/iows_checker.sv
bench/iows_symbol_checker.sv
bench/i2c_oled_write_sequencer_test.sv
